### design/rkbag_pkg.sv
// Package for the radix-k Bruck allgather schedule generator.
// Holds field widths, record codes and the controller/datapath command types.
// No dependencies.
`timescale 1ns / 1ps

package rkbag_pkg;

   // Field widths.
   localparam int RANK_W   = 6;
   localparam int BLK_W    = 20;
   localparam int EXT_W    = 16;
   localparam int OFF_W    = 52;
   localparam int CNT_W    = 26;
   localparam int KIND_W   = 2;
   localparam int PROD_W   = RANK_W + BLK_W;
   localparam int SCALED_W = PROD_W + EXT_W;
   localparam int DK_W     = 2 * RANK_W;

   // Parameter defaults.
   localparam int DEF_MAX_RANKS = 32;
   localparam int DEF_MAX_RADIX = 32;

   // Reset value of the element extent register.
   localparam logic [EXT_W-1:0] EXT_RESET = 16'd1;

   // Record kinds on the result channel.
   typedef enum logic [KIND_W-1:0] {
      KIND_EXCHANGE = 2'd0,
      KIND_COPY     = 2'd1,
      KIND_NOOP     = 2'd2,
      KIND_INVALID  = 2'd3
   } kind_type;

   // Which record the datapath is building.
   typedef enum logic [1:0] {
      SEL_EXCH = 2'd0,
      SEL_ROT1 = 2'd1,
      SEL_ROT2 = 2'd2,
      SEL_SPEC = 2'd3
   } rec_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        start;
      logic        special;
      logic        mul;
      logic        scale;
      logic        step_j;
      logic        step_phase;
      rec_sel_type sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic invalid;
      logic single;
      logic phase_end;
      logic last_phase;
      logic last_rec;
   } sts_type;

endpackage

### design/rkbag_if.sv
// Handshake interfaces for the request, result and register write channels.
// Depends on rkbag_pkg for field widths.
`timescale 1ns / 1ps

interface rkbag_req_if;
   import rkbag_pkg::*;
   logic              valid;
   logic              ready;
   logic [RANK_W-1:0] own_rank;
   logic [RANK_W-1:0] comm_size;
   logic [RANK_W-1:0] radix;
   logic [BLK_W-1:0]  block_elements;

   modport source (output valid, own_rank, comm_size, radix, block_elements,
                   input ready);
   modport sink   (input valid, own_rank, comm_size, radix, block_elements,
                   output ready);
endinterface

interface rkbag_rsp_if;
   import rkbag_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] record_kind;
   logic [RANK_W-1:0] phase_index;
   logic [RANK_W-1:0] peer_source;
   logic [RANK_W-1:0] peer_destination;
   logic [OFF_W-1:0]  source_offset;
   logic [OFF_W-1:0]  target_offset;
   logic [CNT_W-1:0]  element_count;
   logic              phase_end;
   logic              last_record;

   modport source (output valid, record_kind, phase_index, peer_source,
                   peer_destination, source_offset, target_offset,
                   element_count, phase_end, last_record,
                   input ready);
   modport sink   (input valid, record_kind, phase_index, peer_source,
                   peer_destination, source_offset, target_offset,
                   element_count, phase_end, last_record,
                   output ready);
endinterface

interface rkbag_csr_if;
   import rkbag_pkg::*;
   logic             valid;
   logic             ready;
   logic [EXT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### design/radix_k_bruck_allgather_schedule.sv
// Radix-k Bruck allgather schedule generator, top level.
// An accepted request first goes to a check step. A rejected or single-rank request then gives one
// result word; otherwise each record is built by a multiply step, an extent scale step and an emit
// step, and the emit step holds until the result side is ready.
// One request is worked on at a time; requests are accepted only when idle.
// Reset (synchronous, active high) returns to idle and sets the extent to 1.
// Depends on rkbag_pkg, rkbag_if, rkbag_ctrl and rkbag_dpath.
`timescale 1ns / 1ps

module radix_k_bruck_allgather_schedule #(
   parameter int MAX_RANKS = rkbag_pkg::DEF_MAX_RANKS,
   parameter int MAX_RADIX = rkbag_pkg::DEF_MAX_RADIX
) (
   input logic         clock,
   input logic         reset,
   rkbag_req_if.sink   req_bus,
   rkbag_rsp_if.source rsp_bus,
   rkbag_csr_if.sink   csr_bus
);
   import rkbag_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Register writes are taken at any time.
   assign csr_bus.ready = 1'b1;

   rkbag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rkbag_dpath #(
      .MAX_RANKS (MAX_RANKS),
      .MAX_RADIX (MAX_RADIX)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_write            (csr_bus.valid),
      .csr_data             (csr_bus.data),
      .req_own_rank         (req_bus.own_rank),
      .req_comm_size        (req_bus.comm_size),
      .req_radix            (req_bus.radix),
      .req_block_elements   (req_bus.block_elements),
      .rsp_record_kind      (rsp_bus.record_kind),
      .rsp_phase_index      (rsp_bus.phase_index),
      .rsp_peer_source      (rsp_bus.peer_source),
      .rsp_peer_destination (rsp_bus.peer_destination),
      .rsp_source_offset    (rsp_bus.source_offset),
      .rsp_target_offset    (rsp_bus.target_offset),
      .rsp_element_count    (rsp_bus.element_count),
      .rsp_phase_end        (rsp_bus.phase_end),
      .rsp_last_record      (rsp_bus.last_record)
   );

endmodule

### design/rkbag_ctrl.sv
// Controller state machine of the Bruck allgather schedule generator.
// Depends on rkbag_pkg; drives rkbag_dpath through cmd_type and sts_type.
`timescale 1ns / 1ps

module rkbag_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  rkbag_pkg::sts_type sts,
   output rkbag_pkg::cmd_type cmd
);
   import rkbag_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_SCALE = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   rec_sel_type sel_ff, sel_in;
   logic        rsp_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_fire  = rsp_valid && rsp_ready;

   // Next state and command decode.
   always_comb begin
      state_in       = state_ff;
      sel_in         = sel_ff;
      cmd            = '0;
      cmd.sel        = sel_ff;
      cmd.capture    = req_valid && req_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.invalid || sts.single) begin
               cmd.special = 1'b1;
               sel_in      = SEL_SPEC;
               state_in    = ST_EMIT;
            end else begin
               cmd.start = 1'b1;
               sel_in    = SEL_EXCH;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (sts.last_rec) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MUL;
                  case (sel_ff)
                     SEL_EXCH: begin
                        if (!sts.phase_end) begin
                           cmd.step_j = 1'b1;
                        end else if (sts.last_phase) begin
                           sel_in = SEL_ROT1;
                        end else begin
                           cmd.step_phase = 1'b1;
                        end
                     end
                     SEL_ROT1: sel_in = SEL_ROT2;
                     default:  state_in = ST_IDLE;
                  endcase
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_EXCH;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

`ifndef SYNTHESIS
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request taken while a result word is pending");

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CHECK))
      else $error("accepted request did not go to the check step");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && sts.last_rec) |=> req_ready)
      else $error("block not idle after the final record");

   a_more_records: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !sts.last_rec) |=> (state_ff == ST_MUL))
      else $error("schedule stopped before its final record");
`endif

endmodule

### design/rkbag_dpath.sv
// Datapath of the Bruck allgather schedule generator: request registers,
// phase/step counters, count and offset multipliers and the result register.
// Depends on rkbag_pkg; controlled by rkbag_ctrl.
`timescale 1ns / 1ps

module rkbag_dpath #(
   parameter int MAX_RANKS = rkbag_pkg::DEF_MAX_RANKS,
   parameter int MAX_RADIX = rkbag_pkg::DEF_MAX_RADIX
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rkbag_pkg::cmd_type           cmd,
   output rkbag_pkg::sts_type           sts,
   input  logic                         csr_write,
   input  logic [rkbag_pkg::EXT_W-1:0]  csr_data,
   input  logic [rkbag_pkg::RANK_W-1:0] req_own_rank,
   input  logic [rkbag_pkg::RANK_W-1:0] req_comm_size,
   input  logic [rkbag_pkg::RANK_W-1:0] req_radix,
   input  logic [rkbag_pkg::BLK_W-1:0]  req_block_elements,
   output logic [rkbag_pkg::KIND_W-1:0] rsp_record_kind,
   output logic [rkbag_pkg::RANK_W-1:0] rsp_phase_index,
   output logic [rkbag_pkg::RANK_W-1:0] rsp_peer_source,
   output logic [rkbag_pkg::RANK_W-1:0] rsp_peer_destination,
   output logic [rkbag_pkg::OFF_W-1:0]  rsp_source_offset,
   output logic [rkbag_pkg::OFF_W-1:0]  rsp_target_offset,
   output logic [rkbag_pkg::CNT_W-1:0]  rsp_element_count,
   output logic                         rsp_phase_end,
   output logic                         rsp_last_record
);
   import rkbag_pkg::*;

   localparam logic [RANK_W-1:0] MAX_RANKS_V = RANK_W'(MAX_RANKS);
   localparam logic [RANK_W-1:0] MAX_RADIX_V = RANK_W'(MAX_RADIX);
   localparam logic [RANK_W-1:0] ONE         = RANK_W'(1);
   localparam logic [RANK_W-1:0] TWO         = RANK_W'(2);

   // Request and configuration registers.
   logic [RANK_W-1:0] rank_ff, size_ff, k_ff;
   logic [BLK_W-1:0]  blk_ff;
   logic [EXT_W-1:0]  ext_ff;

   // Schedule counters: distance, step, offset, phase and distance times radix.
   logic [RANK_W-1:0] delta_ff, j_ff, off_ff, phase_ff;
   logic [DK_W-1:0]   dk_ff;

   // Product registers.
   logic [PROD_W-1:0] offblk_ff, full_ff, left_ff;

   // Result register.
   logic [KIND_W-1:0] kind_ff;
   logic [RANK_W-1:0] ph_ff, src_ff, dst_ff;
   logic [OFF_W-1:0]  soff_ff, toff_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              pend_ff, last_ff;

   logic [RANK_W:0]     nxt_off, rank_plus_off, rank_size_off;
   logic [RANK_W-1:0]   size_m_rank, size_m_off, mul_a, mul_b, src_c, dst_c;
   logic                pow_k, shorten;
   logic [SCALED_W-1:0] scaled;
   logic [CNT_W-1:0]    exch_cnt;

   // Status toward the controller.
   assign nxt_off         = {1'b0, off_ff} + {1'b0, delta_ff};
   assign sts.invalid     = (size_ff == '0) || (size_ff > MAX_RANKS_V) || (k_ff < TWO)
                            || (k_ff > MAX_RADIX_V) || (rank_ff >= size_ff);
   assign sts.single      = (size_ff == ONE);
   assign sts.phase_end   = (nxt_off >= {1'b0, size_ff}) || (j_ff == k_ff - ONE);
   assign sts.last_phase  = (dk_ff >= DK_W'(size_ff));
   assign sts.last_rec    = (cmd.sel == SEL_SPEC) || (cmd.sel == SEL_ROT2)
                            || ((cmd.sel == SEL_EXCH) && sts.phase_end
                                && sts.last_phase && (rank_ff == '0));

   // Peers, operand selection and the shortened count of the last phase.
   always_comb begin
      size_m_rank   = size_ff - rank_ff;
      size_m_off    = size_ff - off_ff;
      pow_k         = (dk_ff == DK_W'(size_ff));
      rank_plus_off = {1'b0, rank_ff} + {1'b0, off_ff};
      rank_size_off = {1'b0, rank_ff} + {1'b0, size_ff} - {1'b0, off_ff};
      src_c = (rank_plus_off >= {1'b0, size_ff}) ?
              RANK_W'(rank_plus_off - {1'b0, size_ff}) : rank_plus_off[RANK_W-1:0];
      dst_c = (rank_ff >= off_ff) ? (rank_ff - off_ff) : rank_size_off[RANK_W-1:0];
      case (cmd.sel)
         SEL_ROT1: begin
            mul_a = size_m_rank;
            mul_b = rank_ff;
         end
         SEL_ROT2: begin
            mul_a = rank_ff;
            mul_b = size_m_rank;
         end
         default: begin
            mul_a = off_ff;
            mul_b = delta_ff;
         end
      endcase
      shorten  = sts.last_phase && !pow_k
                 && ((j_ff == k_ff - ONE) || (left_ff < full_ff));
      exch_cnt = shorten ? left_ff : full_ff;
      scaled   = SCALED_W'(offblk_ff) * SCALED_W'(ext_ff);
   end

   // Element extent register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff <= EXT_RESET;
      end else if (csr_write) begin
         ext_ff <= csr_data;
      end
   end

   // Request capture and schedule counters.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rank_ff <= req_own_rank;
         size_ff <= req_comm_size;
         k_ff    <= req_radix;
         blk_ff  <= req_block_elements;
      end
      if (cmd.start) begin
         delta_ff <= ONE;
         off_ff   <= ONE;
         j_ff     <= ONE;
         phase_ff <= '0;
         dk_ff    <= DK_W'(k_ff);
      end else if (cmd.step_j) begin
         j_ff   <= j_ff + ONE;
         off_ff <= nxt_off[RANK_W-1:0];
      end else if (cmd.step_phase) begin
         delta_ff <= dk_ff[RANK_W-1:0];
         off_ff   <= dk_ff[RANK_W-1:0];
         j_ff     <= ONE;
         phase_ff <= phase_ff + ONE;
         dk_ff    <= DK_W'(dk_ff[RANK_W-1:0]) * DK_W'(k_ff);
      end
   end

   // Element products of the current record.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         offblk_ff <= PROD_W'(mul_a) * PROD_W'(blk_ff);
         full_ff   <= PROD_W'(mul_b) * PROD_W'(blk_ff);
         left_ff   <= PROD_W'(size_m_off) * PROD_W'(blk_ff);
      end
   end

   // Result register: special records or scaled exchange and copy records.
   always_ff @(posedge clock) begin
      if (cmd.special) begin
         kind_ff <= sts.invalid ? KIND_INVALID : KIND_NOOP;
         ph_ff   <= '0;
         src_ff  <= '0;
         dst_ff  <= '0;
         soff_ff <= '0;
         toff_ff <= '0;
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
         last_ff <= 1'b1;
      end else if (cmd.scale) begin
         last_ff <= sts.last_rec;
         case (cmd.sel)
            SEL_EXCH: begin
               kind_ff <= KIND_EXCHANGE;
               ph_ff   <= phase_ff;
               src_ff  <= src_c;
               dst_ff  <= dst_c;
               soff_ff <= '0;
               toff_ff <= OFF_W'(scaled);
               cnt_ff  <= exch_cnt;
               pend_ff <= sts.phase_end;
            end
            SEL_ROT1: begin
               kind_ff <= KIND_COPY;
               ph_ff   <= '0;
               src_ff  <= '0;
               dst_ff  <= '0;
               soff_ff <= OFF_W'(scaled);
               toff_ff <= '0;
               cnt_ff  <= full_ff;
               pend_ff <= 1'b0;
            end
            default: begin
               kind_ff <= KIND_COPY;
               ph_ff   <= '0;
               src_ff  <= '0;
               dst_ff  <= '0;
               soff_ff <= '0;
               toff_ff <= OFF_W'(scaled);
               cnt_ff  <= full_ff;
               pend_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_record_kind      = kind_ff;
   assign rsp_phase_index      = ph_ff;
   assign rsp_peer_source      = src_ff;
   assign rsp_peer_destination = dst_ff;
   assign rsp_source_offset    = soff_ff;
   assign rsp_target_offset    = toff_ff;
   assign rsp_element_count    = cnt_ff;
   assign rsp_phase_end        = pend_ff;
   assign rsp_last_record      = last_ff;

endmodule
